// ===== hdl/allocation_leak_tracker_unit_macros.svh =====
// Assertion macros for the allocation leak tracker.
`ifndef ALLOCATION_LEAK_TRACKER_UNIT_MACROS_SVH
`define ALLOCATION_LEAK_TRACKER_UNIT_MACROS_SVH

// An implication that must hold at every clock edge out of reset.
`define ALT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequence must hold in the cycle after the antecedent.
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/alt_pkg.sv =====
`timescale 1ns / 1ps

package alt_pkg;

    localparam int FUNC_W = 3;
    localparam int CLIENT_W = 5;
    localparam int ADDR_W = 64;
    localparam int SIZE_W = 40;
    localparam int STATUS_W = 4;
    localparam int CNT_W = 9;
    localparam int BYTES_W = 48;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DANGLING = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OVERFLOW = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_EXT_DOUBLE = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_RECORDED = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 4'd1;
    localparam logic [STATUS_W-1:0] ST_FREED = 4'd2;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 4'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DANGLING = 4'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd6;
    localparam logic [STATUS_W-1:0] ST_EXT_DOUBLE = 4'd7;
    localparam logic [STATUS_W-1:0] ST_REPORT = 4'd8;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CLIENT_W-1:0] client;
        logic [ADDR_W-1:0]   address;
        logic [SIZE_W-1:0]   alloc_size;
    } alt_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    total_count;
        logic [CNT_W-1:0]    freed_count;
        logic [CNT_W-1:0]    leak_count;
        logic [BYTES_W-1:0]  lost_bytes;
        logic [CNT_W-1:0]    double_free_count;
    } alt_rsp_t;

endpackage

// ===== hdl/allocation_leak_tracker_unit.sv =====
`timescale 1ns / 1ps

// Per-client allocation tracker: each request returns one response. Allocate and
// acknowledge requests go from idle straight to the output state; a free walks the
// client's table newest first and a report walks it oldest first, taking each entry
// through the issue, wait and check states of the entry memory read. A stalled
// response holds the engine. A two-deep request queue lets the next request be
// taken while one is in work.
`include "allocation_leak_tracker_unit_macros.svh"

module allocation_leak_tracker_unit
    import alt_pkg::*;
#(
    parameter int CLIENTS = 32,
    parameter int ENTRIES_PER_CLIENT = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  alt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output alt_rsp_t rsp
);

    logic     q_valid;
    logic     q_ready;
    alt_req_t q_data;

    alt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    alt_back #(
        .CLIENTS (CLIENTS),
        .ENTRIES (ENTRIES_PER_CLIENT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `ALT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "response changed while stalled")
    `ALT_ASSERT_IMPL(a_no_take_busy, clk, rst_n, rsp_valid, !q_ready,
        "queue popped while response pending")
    `ALT_ASSERT_IMPL(a_report_only, clk, rst_n, rsp_valid && rsp.status != ST_REPORT,
        rsp.total_count == '0 && rsp.lost_bytes == '0, "counts set outside report")

endmodule

// ===== hdl/alt_front.sv =====
`timescale 1ns / 1ps

module alt_front
    import alt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  alt_req_t req,
    output logic     q_valid,
    input  logic     q_ready,
    output alt_req_t q_data
);

    // Two-entry queue between intake and execution.
    alt_req_t   slot_reg [2];
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wptr_reg;
    logic       rptr_reg;

    wire push = req_valid && req_ready;
    wire pop = q_valid && q_ready;

    assign req_ready = fill_reg != 2'd2;
    assign q_valid = fill_reg != 2'd0;
    assign q_data = slot_reg[rptr_reg];

    always_comb
    begin
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wptr_reg] <= req;
    end

endmodule

// ===== hdl/alt_back.sv =====
`timescale 1ns / 1ps

module alt_back
    import alt_pkg::*;
#(
    parameter int CLIENTS = 32,
    parameter int ENTRIES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_ready,
    input  alt_req_t q_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output alt_rsp_t rsp
);

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);
    localparam int AW = CW + EW;
    localparam int DEPTH = CLIENTS * (2 ** EW);
    localparam int MW = ADDR_W + SIZE_W + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_WAIT  = 5'b00100,
        S_CHECK = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    logic [MW-1:0]   mem [DEPTH];
    logic [MW-1:0]   rd_reg;
    logic [CNTW-1:0] count_reg [CLIENTS];

    state_t          state_reg;
    alt_req_t        cur_reg;
    logic            ok_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] idx_reg;
    logic [CNTW-1:0] rd_idx_reg;
    logic [CNTW-1:0]    leak_reg;
    logic [CNTW-1:0]    dbl_reg;
    logic [BYTES_W-1:0] bytes_reg;
    alt_rsp_t        rsp_reg;
    logic            rsp_valid_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [MW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    wire [CW-1:0] cl = CW'(q_data.client);
    wire cl_ok = {27'd0, q_data.client} < 32'(CLIENTS);
    wire [CW-1:0] ccl = CW'(cur_reg.client);
    wire [ADDR_W-1:0] m_addr = rd_reg[MW-1 -: ADDR_W];
    wire [SIZE_W-1:0] m_size = rd_reg[SIZE_W+1:2];
    wire m_freed = rd_reg[1];
    wire m_dbl = rd_reg[0];
    wire is_free = cur_reg.func == FUNC_FREE;
    wire [BYTES_W:0] bsum = {1'b0, bytes_reg} + {{(BYTES_W-SIZE_W+1){1'b0}}, m_size};

    assign q_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    function automatic logic [CNT_W-1:0] sat(input logic [CNTW-1:0] v);
        logic [CNT_W-1:0] r;
        if ({{(32-CNTW){1'b0}}, v} > 32'(CNT_MAX))
            r = CNT_MAX;
        else
            r = CNT_W'(v);
        return r;
    endfunction

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = {ccl, idx_reg[EW-1:0]};
        wr_data = {cur_reg.address, cur_reg.alloc_size, 2'b00};
        rd_en = state_reg == S_ISSUE;
        rd_addr = {ccl, rd_idx_reg[EW-1:0]};
        if (state_reg == S_CHECK && is_free && m_addr == cur_reg.address)
        begin
            wr_en = 1'b1;
            wr_addr = {ccl, rd_idx_reg[EW-1:0]};
            wr_data = {rd_reg[MW-1:2], 1'b1, m_freed};
        end
        else if (state_reg == S_OUT && cur_reg.func == FUNC_ALLOC && ok_reg
                 && {{(32-CNTW){1'b0}}, cnt_reg} < 32'(ENTRIES))
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < CLIENTS; c++)
                count_reg[c] <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        cur_reg <= q_data;
                        ok_reg <= cl_ok;
                        cnt_reg <= cl_ok ? count_reg[cl] : '0;
                        idx_reg <= cl_ok ? count_reg[cl] : '0;
                        rd_idx_reg <= '0;
                        leak_reg <= '0;
                        dbl_reg <= '0;
                        bytes_reg <= '0;
                        rsp_reg <= '0;
                        priority if (q_data.func == FUNC_ALLOC)
                            state_reg <= S_OUT;
                        else if ((q_data.func == FUNC_FREE || q_data.func == FUNC_REPORT)
                                 && cl_ok && count_reg[cl] != '0)
                        begin
                            rd_idx_reg <= (q_data.func == FUNC_FREE)
                                ? count_reg[cl] - 1'b1 : '0;
                            state_reg <= S_ISSUE;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_ISSUE:
                    state_reg <= S_WAIT;
                S_WAIT:
                    state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (is_free)
                    begin
                        if (m_addr == cur_reg.address)
                        begin
                            rsp_reg.status <= m_freed ? ST_DOUBLE : ST_FREED;
                            state_reg <= S_OUT;
                        end
                        else if (rd_idx_reg == '0)
                            state_reg <= S_OUT;
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg - 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                    else
                    begin
                        if (!m_freed)
                        begin
                            leak_reg <= leak_reg + 1'b1;
                            bytes_reg <= bsum[BYTES_W] ? BYTES_MAX : bsum[BYTES_W-1:0];
                        end
                        if (m_dbl)
                            dbl_reg <= dbl_reg + 1'b1;
                        if (rd_idx_reg + 1'b1 == cnt_reg)
                            state_reg <= S_OUT;
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_OUT:
                begin
                    rsp_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    unique case (cur_reg.func)
                        FUNC_ALLOC:
                        begin
                            if (!ok_reg || {{(32-CNTW){1'b0}}, cnt_reg} >= 32'(ENTRIES))
                                rsp_reg.status <= ST_FULL;
                            else
                            begin
                                rsp_reg.status <= ST_RECORDED;
                                count_reg[ccl] <= cnt_reg + 1'b1;
                            end
                        end
                        FUNC_FREE:
                            if (rsp_reg.status != ST_FREED && rsp_reg.status != ST_DOUBLE)
                                rsp_reg.status <= ST_UNKNOWN;
                        FUNC_DANGLING:
                            rsp_reg.status <= ST_DANGLING;
                        FUNC_OVERFLOW:
                            rsp_reg.status <= ST_OVERFLOW;
                        FUNC_EXT_DOUBLE:
                            rsp_reg.status <= ST_EXT_DOUBLE;
                        FUNC_REPORT:
                        begin
                            rsp_reg.status <= ST_REPORT;
                            rsp_reg.total_count <= sat(cnt_reg);
                            rsp_reg.leak_count <= sat(leak_reg);
                            rsp_reg.freed_count <= sat(cnt_reg - leak_reg);
                            rsp_reg.lost_bytes <= bytes_reg;
                            rsp_reg.double_free_count <= sat(dbl_reg);
                            if (ok_reg)
                                count_reg[ccl] <= '0;
                        end
                        default:
                            rsp_reg.status <= ST_UNKNOWN;
                    endcase
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
